/* hdl/amfa_pkg.sv */
// Package: widths, types, register indexes and the funnel shift of the fraction adder.
`default_nettype none
package amfa_pkg;

	localparam int unsigned LIMB_BITS = 64;
	localparam int unsigned AMFA_MAX_LIMBS = 8;
	localparam int unsigned CNT_REG_W = 4;
	localparam int unsigned SHIFT_REG_W = 10;
	localparam int unsigned CFG_DATA_W = 10;
	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned POS_W = 3;
	localparam int unsigned BIT_IDX_W = $clog2(LIMB_BITS);

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_A_LIMBS   = 3'd0,
		REG_B_LIMBS   = 3'd1,
		REG_OUT_LIMBS = 3'd2,
		REG_SHIFT_A   = 3'd3,
		REG_SHIFT_B   = 3'd4
	} amfa_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN
	} amfa_state_t;

	typedef struct packed {
		logic                 command;
		logic [LIMB_BITS-1:0] limb_value;
		logic                 final_item;
	} amfa_item_t;

	typedef struct packed {
		logic [LIMB_BITS-1:0] result_limb;
		logic [POS_W-1:0]     limb_position;
		logic                 last_limb;
	} amfa_result_t;

	typedef struct packed {
		logic load;
		logic start_run;
		logic issue;
	} amfa_cmd_t;

	typedef struct packed {
		logic issue_last;
		logic drain_done;
	} amfa_stat_t;

	// Low limb of the two-limb word {hi, lo} shifted right by r bits.
	function automatic logic [LIMB_BITS-1:0] funnel_right(
		input logic [LIMB_BITS-1:0] hi,
		input logic [LIMB_BITS-1:0] lo,
		input logic [BIT_IDX_W-1:0] r
	);
		logic [2*LIMB_BITS-1:0] w;
		w = {hi, lo} >> r;
		return w[LIMB_BITS-1:0];
	endfunction

endpackage
`default_nettype wire

/* hdl/amfa_mem.sv */
// Limb store: one write port and two registered read ports.
`default_nettype none
module amfa_mem import amfa_pkg::*; #(
	parameter int unsigned DEPTH = AMFA_MAX_LIMBS,
	parameter int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [AW-1:0]        waddr,
	input  wire logic [LIMB_BITS-1:0] wdata,
	input  wire logic [AW-1:0]        raddr0,
	input  wire logic [AW-1:0]        raddr1,
	output logic      [LIMB_BITS-1:0] rdata0_q,
	output logic      [LIMB_BITS-1:0] rdata1_q
);

	logic [LIMB_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata0_q <= mem[raddr0];
		rdata1_q <= mem[raddr1];
	end

endmodule
`default_nettype wire

/* hdl/amfa_ctrl.sv */
// Controller: load, issue and drain sequencing of the fraction adder.
`default_nettype none
module amfa_ctrl import amfa_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic       final_item,
	input  wire amfa_stat_t stat,
	output amfa_cmd_t       cmd,
	output logic            busy
);

	amfa_state_t state_q;
	amfa_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start && final_item) begin
					state_next = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				if (stat.issue_last) begin
					state_next = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (stat.drain_done) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy          = 1'b0;
				cmd.load      = start;
				cmd.start_run = start && final_item;
			end
			ST_ISSUE: begin
				cmd.issue = 1'b1;
			end
			ST_DRAIN: begin
				cmd.issue = 1'b0;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule
`default_nettype wire

/* hdl/amfa_datapath.sv */
// Datapath: configuration registers, limb stores, alignment, funnel shifts and carry add.
`default_nettype none
module amfa_datapath import amfa_pkg::*; #(
	parameter int unsigned MAX_LIMBS = AMFA_MAX_LIMBS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire amfa_item_t            item,
	input  wire amfa_cmd_t             cmd,
	output amfa_stat_t                 stat,
	output amfa_result_t               result,
	output logic                       result_valid
);

	localparam int unsigned AW = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS) : 1;
	localparam int unsigned CW = $clog2(MAX_LIMBS + 1);
	// Signed limb index: spans operand length, window and the whole-limb part of a shift.
	localparam int unsigned LW = $clog2(MAX_LIMBS) + 6;
	localparam int unsigned SH_HI = SHIFT_REG_W - BIT_IDX_W;

	// Configuration registers.
	logic [CNT_REG_W-1:0]   a_cnt_q, b_cnt_q, o_cnt_q;
	logic [SHIFT_REG_W-1:0] shift_a_q, shift_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_cnt_q   <= CNT_REG_W'(1);
			b_cnt_q   <= CNT_REG_W'(1);
			o_cnt_q   <= CNT_REG_W'(1);
			shift_a_q <= '0;
			shift_b_q <= '0;
		end else if (cfg_we) begin
			case (amfa_reg_t'(cfg_addr))
				REG_A_LIMBS:   a_cnt_q   <= cfg_data[CNT_REG_W-1:0];
				REG_B_LIMBS:   b_cnt_q   <= cfg_data[CNT_REG_W-1:0];
				REG_OUT_LIMBS: o_cnt_q   <= cfg_data[CNT_REG_W-1:0];
				REG_SHIFT_A:   shift_a_q <= cfg_data[SHIFT_REG_W-1:0];
				REG_SHIFT_B:   shift_b_q <= cfg_data[SHIFT_REG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	function automatic logic [CW-1:0] clamp_cnt(input logic [CNT_REG_W-1:0] c);
		logic [CW-1:0] v;
		if (c == '0) begin
			v = CW'(1);
		end else if (int'(c) > int'(MAX_LIMBS)) begin
			v = CW'(MAX_LIMBS);
		end else begin
			v = CW'(c);
		end
		return v;
	endfunction

	logic [CW-1:0] na, nb, oc;
	assign na = clamp_cnt(a_cnt_q);
	assign nb = clamp_cnt(b_cnt_q);
	assign oc = clamp_cnt(o_cnt_q);

	// Load counters; the final transfer stores its limb and then clears them.
	logic [CW-1:0] a_loaded_q, b_loaded_q;
	logic          a_we, b_we;

	assign a_we = cmd.load && !item.command && (int'(a_loaded_q) < int'(MAX_LIMBS));
	assign b_we = cmd.load &&  item.command && (int'(b_loaded_q) < int'(MAX_LIMBS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_loaded_q <= '0;
			b_loaded_q <= '0;
		end else if (cmd.start_run) begin
			a_loaded_q <= '0;
			b_loaded_q <= '0;
		end else begin
			if (a_we) begin
				a_loaded_q <= a_loaded_q + CW'(1);
			end
			if (b_we) begin
				b_loaded_q <= b_loaded_q + CW'(1);
			end
		end
	end

	// Output limb counter.
	logic [CW-1:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.start_run) begin
			idx_q <= '0;
		end else if (cmd.issue) begin
			idx_q <= idx_q + CW'(1);
		end
	end

	assign stat.issue_last = cmd.issue && (idx_q == oc - CW'(1));

	// Output limb i of an operand takes bits from 64*(n-oc+i) - s upward, i.e. limb lo
	// shifted right by r with limb lo+1 above it.
	logic [LW-1:0]        lo_a, lo_b, hi_a, hi_b;
	logic [BIT_IDX_W-1:0] r_a, r_b;
	logic                 lo_a_ok, hi_a_ok, lo_b_ok, hi_b_ok;

	assign lo_a = LW'(na) - LW'(oc) + LW'(idx_q) - LW'(shift_a_q[SHIFT_REG_W-1 -: SH_HI])
	            - LW'(shift_a_q[BIT_IDX_W-1:0] != '0);
	assign lo_b = LW'(nb) - LW'(oc) + LW'(idx_q) - LW'(shift_b_q[SHIFT_REG_W-1 -: SH_HI])
	            - LW'(shift_b_q[BIT_IDX_W-1:0] != '0);
	assign hi_a = lo_a + LW'(1);
	assign hi_b = lo_b + LW'(1);
	assign r_a  = BIT_IDX_W'(0) - shift_a_q[BIT_IDX_W-1:0];
	assign r_b  = BIT_IDX_W'(0) - shift_b_q[BIT_IDX_W-1:0];

	assign lo_a_ok = !lo_a[LW-1] && (lo_a < LW'(na));
	assign hi_a_ok = !hi_a[LW-1] && (hi_a < LW'(na));
	assign lo_b_ok = !lo_b[LW-1] && (lo_b < LW'(nb));
	assign hi_b_ok = !hi_b[LW-1] && (hi_b < LW'(nb));

	logic [LIMB_BITS-1:0] a_lo_s1, a_hi_s1, b_lo_s1, b_hi_s1;

	amfa_mem #(.DEPTH(MAX_LIMBS), .AW(AW)) u_a_mem (
		.clk      (clk),
		.we       (a_we),
		.waddr    (a_loaded_q[AW-1:0]),
		.wdata    (item.limb_value),
		.raddr0   (lo_a[AW-1:0]),
		.raddr1   (hi_a[AW-1:0]),
		.rdata0_q (a_lo_s1),
		.rdata1_q (a_hi_s1)
	);

	amfa_mem #(.DEPTH(MAX_LIMBS), .AW(AW)) u_b_mem (
		.clk      (clk),
		.we       (b_we),
		.waddr    (b_loaded_q[AW-1:0]),
		.wdata    (item.limb_value),
		.raddr0   (lo_b[AW-1:0]),
		.raddr1   (hi_b[AW-1:0]),
		.rdata0_q (b_lo_s1),
		.rdata1_q (b_hi_s1)
	);

	// Stage 1: read data (inside the stores) with its alignment and tags.
	logic                 valid_s1, first_s1, last_s1;
	logic [POS_W-1:0]     pos_s1;
	logic [BIT_IDX_W-1:0] r_a_s1, r_b_s1;
	logic                 lo_a_ok_s1, hi_a_ok_s1, lo_b_ok_s1, hi_b_ok_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
		end
	end

	always_ff @(posedge clk) begin
		first_s1   <= (idx_q == '0);
		last_s1    <= (idx_q == oc - CW'(1));
		pos_s1     <= POS_W'(idx_q);
		r_a_s1     <= r_a;
		r_b_s1     <= r_b;
		lo_a_ok_s1 <= lo_a_ok;
		hi_a_ok_s1 <= hi_a_ok;
		lo_b_ok_s1 <= lo_b_ok;
		hi_b_ok_s1 <= hi_b_ok;
	end

	// Stage 2: aligned limbs; an index outside the operand reads as zero.
	logic                 valid_s2, first_s2, last_s2;
	logic [POS_W-1:0]     pos_s2;
	logic [LIMB_BITS-1:0] x_s2, y_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		pos_s2   <= pos_s1;
		x_s2     <= funnel_right(hi_a_ok_s1 ? a_hi_s1 : '0, lo_a_ok_s1 ? a_lo_s1 : '0, r_a_s1);
		y_s2     <= funnel_right(hi_b_ok_s1 ? b_hi_s1 : '0, lo_b_ok_s1 ? b_lo_s1 : '0, r_b_s1);
	end

	assign stat.drain_done = valid_s2 && last_s2;

	// Stage 3: limb-serial add; the carry starts at zero on the first limb of a run.
	logic                 carry_q;
	logic                 carry_in;
	logic [LIMB_BITS:0]   sum;
	amfa_result_t         result_q;
	logic                 result_valid_q;

	assign carry_in = first_s2 ? 1'b0 : carry_q;
	assign sum = {1'b0, x_s2} + {1'b0, y_s2} + (LIMB_BITS + 1)'(carry_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= valid_s2;
			if (valid_s2) begin
				carry_q <= sum[LIMB_BITS];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			result_q.result_limb   <= sum[LIMB_BITS-1:0];
			result_q.limb_position <= pos_s2;
			result_q.last_limb     <= last_s2;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule
`default_nettype wire

/* hdl/aligned_multilimb_fraction_add.sv */
// Top level of the aligned multi-limb fraction adder.
//
// Input channel: an item transfers at a rising edge with start high and busy low. Items
// carry one 64-bit limb of operand a or b, least significant first; a limb beyond the
// store depth of its operand is dropped. The item with final_item set stores its limb
// and starts the sum; busy rises on the next cycle and no item transfers until it falls.
// Result channel: result_valid marks each result for exactly one cycle and the receiver
// must take it then. A run emits out_limb_count limbs, least significant first, on
// consecutive cycles; after the final transfer the first limb passes the sequencer
// state, store read, funnel shift and carry add registers. Non-final limbs can transfer
// back to back. Configuration: cfg_we writes cfg_data to register cfg_addr; the user
// must write only while idle, and the block itself does not enforce it.
// Reset clears the load counters, carry and sequencer and sets the registers to their
// defaults; stored limbs are not cleared.
`default_nettype none
module aligned_multilimb_fraction_add import amfa_pkg::*; #(
	parameter int unsigned MAX_LIMBS = AMFA_MAX_LIMBS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  start,
	input  wire amfa_item_t            item,
	output logic                       busy,
	output amfa_result_t               result,
	output logic                       result_valid
);

	amfa_cmd_t  cmd;
	amfa_stat_t stat;

	amfa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.final_item (item.final_item),
		.stat       (stat),
		.cmd        (cmd),
		.busy       (busy)
	);

	amfa_datapath #(.MAX_LIMBS(MAX_LIMBS)) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_data     (cfg_data),
		.item         (item),
		.cmd          (cmd),
		.stat         (stat),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule
`default_nettype wire

/* hdl/amfa_checker.sv */
// Port-level checker of the fraction adder and its bind to the top level.
`default_nettype none
module amfa_checker import amfa_pkg::*; (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         start,
	input wire amfa_item_t   item,
	input wire logic         busy,
	input wire amfa_result_t result,
	input wire logic         result_valid
);

	// A run's limbs come back to back until the most significant one.
	a_run_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_limb |=> result_valid)
		else $error("result run broken before its last limb");

	// Positions count up by one within a run.
	a_position_steps: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_limb |=>
			result.limb_position == $past(result.limb_position) + POS_W'(1))
		else $error("result limb position did not advance by one");

	// Every run opens at the least significant limb.
	a_run_opens_low: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> result.limb_position == '0)
		else $error("result run did not start at position zero");

	// The last limb of a run is followed by a gap.
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last_limb |=> !result_valid)
		else $error("result strobe continued after the last limb");

	// A final transfer makes the block busy.
	a_final_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.final_item |=> busy)
		else $error("busy did not rise after the final transfer");

endmodule

bind aligned_multilimb_fraction_add amfa_checker u_amfa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.item         (item),
	.busy         (busy),
	.result       (result),
	.result_valid (result_valid)
);
`default_nettype wire
